>>> design/arr_pkg.sv
package arr_pkg;

  // operand width of both inputs and all results
  localparam int OPERAND_BITS = 16;
  // bits for a count of shared factors of two, or of divider steps
  localparam int STEP_BITS = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [STEP_BITS-1:0]    step_t;

  // top-level sequencer
  typedef enum logic [1:0] {
    T_IDLE,
    T_GCD,
    T_DIV_W,
    T_DIV_H
  } top_state_e;

  // binary divisor search
  typedef enum logic [1:0] {
    G_IDLE,
    G_REDUCE,
    G_SCALE
  } gcd_state_e;

  // request to the serial divider
  typedef struct packed {
    logic     start;
    operand_t dividend;
    operand_t divisor;
  } div_req_t;

  // answer from the serial divider
  typedef struct packed {
    logic     done;
    operand_t quotient;
  } div_rsp_t;

endpackage

>>> design/arr_gcd.sv
module arr_gcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  arr_pkg::operand_t a_i,
  input  arr_pkg::operand_t b_i,
  output logic              done_o,
  output arr_pkg::operand_t gcd_o
);
  import arr_pkg::*;

  gcd_state_e state_q, state_d;
  operand_t   a_q, a_d;
  operand_t   b_q, b_d;
  step_t      k_q, k_d;
  logic       done_q, done_d;
  operand_t   diff;
  logic       a_gt_b;

  // one compare and subtract per step
  assign a_gt_b = a_q > b_q;
  assign diff   = a_gt_b ? (a_q - b_q) : (b_q - a_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      G_IDLE: begin
        if (start_i) state_d = G_REDUCE;
      end
      G_REDUCE: begin
        if (b_q == '0) state_d = G_SCALE;
      end
      G_SCALE: begin
        if (k_q == '0) state_d = G_IDLE;
      end
      default: state_d = G_IDLE;
    endcase
  end

  // datapath: strip twos, subtract odd values, then restore shared twos
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    done_d = 1'b0;
    case (state_q)
      G_IDLE: begin
        if (start_i) begin
          a_d = a_i;
          b_d = b_i;
          k_d = '0;
        end
      end
      G_REDUCE: begin
        if (b_q == '0) begin
          a_d = a_q;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + step_t'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else begin
          if (a_gt_b) a_d = b_q;
          b_d = diff;
        end
      end
      G_SCALE: begin
        if (k_q == '0) begin
          done_d = 1'b1;
        end else begin
          a_d = a_q << 1;
          k_d = k_q - step_t'(1);
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // advance operands
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  assign done_o = done_q;
  assign gcd_o  = a_q;

endmodule

>>> design/arr_div.sv
module arr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arr_pkg::div_req_t req_i,
  output arr_pkg::div_rsp_t rsp_o
);
  import arr_pkg::*;

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  step_t                 cnt_q, cnt_d;
  operand_t              rem_q, rem_d;
  operand_t              quo_q, quo_d;
  operand_t              den_q, den_d;
  logic [OPERAND_BITS:0] trial;
  logic [OPERAND_BITS:0] shifted;
  logic                  fits;

  // bring down the next dividend bit and try the divisor
  assign shifted = {rem_q, quo_q[OPERAND_BITS-1]};
  assign fits    = shifted >= {1'b0, den_q};
  assign trial   = shifted - {1'b0, den_q};

  // one quotient bit per cycle
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = step_t'(OPERAND_BITS - 1);
      rem_d = '0;
      quo_d = req_i.dividend;
      den_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = fits ? trial[OPERAND_BITS-1:0] : shifted[OPERAND_BITS-1:0];
      quo_d = {quo_q[OPERAND_BITS-2:0], fits};
      cnt_d = cnt_q - step_t'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // shift the remainder and quotient words
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> design/aspect_ratio_reducer_top.sv
// Reduces a width/height word to its simplest ratio. A word is taken when
// start_i is high and busy_o is low; one result follows, shown for a single
// cycle with valid_o high, and it must be captured then since the receiver
// cannot stall the block. If either operand is zero the result comes the
// next cycle with invalid_o set and all other fields zero. Otherwise the
// binary divisor search runs one shift or subtract per cycle, then doubles
// the result once per shared factor of two and hands over the divisor; the
// serial divider then produces each ratio at one quotient bit per cycle.
// busy_o stays high for the whole computation and the result shows in the
// cycle in which it falls.
module aspect_ratio_reducer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  arr_pkg::operand_t width_in_i,
  input  arr_pkg::operand_t height_in_i,
  output logic              valid_o,
  output arr_pkg::operand_t common_divisor_o,
  output arr_pkg::operand_t ratio_width_o,
  output arr_pkg::operand_t ratio_height_o,
  output logic              invalid_o
);
  import arr_pkg::*;

  top_state_e state_q, state_d;
  operand_t   w_q, h_q, g_q;
  operand_t   rw_q, rh_q;
  logic       inv_q;
  logic       valid_q, valid_d;
  logic       take, zero_op;
  logic       gcd_start, gcd_done;
  operand_t   gcd_val;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic       load_op, load_g, load_rw, load_rh, load_zero;

  assign take    = start_i && (state_q == T_IDLE);
  assign zero_op = (width_in_i == '0) || (height_in_i == '0);

  arr_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (width_in_i),
    .b_i     (height_in_i),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  arr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (take && !zero_op) state_d = T_GCD;
      end
      T_GCD: begin
        if (gcd_done) state_d = T_DIV_W;
      end
      T_DIV_W: begin
        if (div_rsp.done) state_d = T_DIV_H;
      end
      T_DIV_H: begin
        if (div_rsp.done) state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    gcd_start        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = h_q;
    div_req.divisor  = g_q;
    load_op          = 1'b0;
    load_g           = 1'b0;
    load_rw          = 1'b0;
    load_rh          = 1'b0;
    load_zero        = 1'b0;
    valid_d          = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (take && zero_op) begin
          load_zero = 1'b1;
          valid_d   = 1'b1;
        end else if (take) begin
          gcd_start = 1'b1;
          load_op   = 1'b1;
        end
      end
      T_GCD: begin
        div_req.dividend = w_q;
        div_req.divisor  = gcd_val;
        if (gcd_done) begin
          div_req.start = 1'b1;
          load_g        = 1'b1;
        end
      end
      T_DIV_W: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          load_rw       = 1'b1;
        end
      end
      T_DIV_H: begin
        if (div_rsp.done) begin
          load_rh = 1'b1;
          valid_d = 1'b1;
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // capture operands and results
  always_ff @(posedge clk_i) begin
    if (load_op) begin
      w_q   <= width_in_i;
      h_q   <= height_in_i;
      inv_q <= 1'b0;
    end
    if (load_g) g_q <= gcd_val;
    if (load_rw) rw_q <= div_rsp.quotient;
    if (load_rh) rh_q <= div_rsp.quotient;
    if (load_zero) begin
      g_q   <= '0;
      rw_q  <= '0;
      rh_q  <= '0;
      inv_q <= 1'b1;
    end
  end

  assign busy_o           = state_q != T_IDLE;
  assign valid_o          = valid_q;
  assign common_divisor_o = g_q;
  assign ratio_width_o    = rw_q;
  assign ratio_height_o   = rh_q;
  assign invalid_o        = inv_q;

endmodule

>>> design/arr_checker.sv
module arr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input arr_pkg::operand_t width_in_i,
  input arr_pkg::operand_t height_in_i,
  input logic              valid_o,
  input arr_pkg::operand_t common_divisor_o,
  input arr_pkg::operand_t ratio_width_o,
  input arr_pkg::operand_t ratio_height_o,
  input logic              invalid_o
);

  // a zero operand answers on the next cycle with a flagged, zeroed word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (width_in_i == '0 || height_in_i == '0) |=>
      valid_o && invalid_o && common_divisor_o == '0 && ratio_width_o == '0 &&
      ratio_height_o == '0)
    else $error("zero operand not flagged");

  // a nonzero pair starts a computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && width_in_i != '0 && height_in_i != '0 |=> busy_o)
    else $error("nonzero word did not start");

  // a good result never carries a zero divisor or ratio
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !invalid_o |->
      common_divisor_o != '0 && ratio_width_o != '0 && ratio_height_o != '0)
    else $error("zero field in valid result");

  // results appear only once the block is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result while busy");

  // finishing a computation delivers its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o && !invalid_o)
    else $error("computation ended without result");

endmodule

bind aspect_ratio_reducer_top arr_checker u_arr_checker (.*);
